### hw/rtl/triclinic_minimum_image_distance_defines.svh
// Assertion macros shared by the triclinic minimum-image distance RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef TRICLINIC_MINIMUM_IMAGE_DISTANCE_DEFINES_SVH
`define TRICLINIC_MINIMUM_IMAGE_DISTANCE_DEFINES_SVH
`ifndef SYNTHESIS
`define TMID_ASSERT_NOW(label, clk, rst_n, cond, res) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (res)) \
		else $error("assertion failed");
`define TMID_ASSERT_NEXT(label, clk, rst_n, cond, res) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
		else $error("assertion failed");
`else
`define TMID_ASSERT_NOW(label, clk, rst_n, cond, res)
`define TMID_ASSERT_NEXT(label, clk, rst_n, cond, res)
`endif
`endif

### hw/rtl/tmid_pkg.sv
// Types and constants of the triclinic minimum-image distance block.
// No dependencies; imported by every module of the block.
`default_nettype none

package tmid_pkg;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOX_A_X,
		REG_BOX_B_X,
		REG_BOX_B_Y,
		REG_BOX_C_X,
		REG_BOX_C_Y,
		REG_BOX_C_Z
	} cfg_reg_t;

	localparam logic [30:0] BOX_DIAG_RESET = 31'd655360;
	localparam logic [30:0] WRAP_LIMIT = 31'h4000_0000;

	typedef struct packed {
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] first_z;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic signed [31:0] second_z;
	} pair_t;

	typedef struct packed {
		logic signed [31:0] disp_x;
		logic signed [31:0] disp_y;
		logic signed [31:0] disp_z;
		logic        [30:0] distance;
	} result_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh7fff_ffff) return 32'sh7fff_ffff;
		else if (v < -64'sh8000_0000) return 32'sh8000_0000;
		else return v[31:0];
	endfunction

endpackage

`default_nettype wire

### hw/rtl/tmid_rdiv.sv
// Pipelined rounding divider: round(num/den) half away from zero, saturated to
// plus or minus 2^30, zero for a zero divisor. Uses tmid_pkg.
`default_nettype none

module tmid_rdiv
	import tmid_pkg::*;
#(
	parameter int PW = 192
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [63:0]   num,
	input  logic        [30:0]   den,
	input  logic        [PW-1:0] in_pay,
	output logic                 out_valid,
	output logic signed [31:0]   quo,
	output logic        [PW-1:0] out_pay
);

	localparam int QB = 31;

	logic [63:0] mag;
	logic [64:0] nn;
	logic [31:0] dd;
	logic        sat;

	logic [QB:0]    v_s;
	logic [64:0]    rem_s  [0:QB-1];
	logic [QB-1:0]  q_s    [0:QB];
	logic           neg_s  [0:QB];
	logic           sat_s  [0:QB];
	logic           zero_s [0:QB];
	logic [PW-1:0]  pay_s  [0:QB];

	logic [QB-1:0] lim;

	assign mag = num[63] ? 64'(-num) : 64'(num);
	assign nn  = {mag, 1'b0} + 65'(den);
	assign dd  = {den, 1'b0};
	assign sat = nn[64:31] >= 34'(dd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s       <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s       <= {v_s[QB-1:0], in_valid};
			out_valid <= v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= nn;
			q_s[0]    <= '0;
			neg_s[0]  <= num[63];
			sat_s[0]  <= sat;
			zero_s[0] <= (den == '0);
			pay_s[0]  <= in_pay;
		end
	end

	for (genvar s = 1; s <= QB; s++) begin : g_it
		localparam int B = QB - s;
		logic [64:0] dsh;
		logic        ge;

		assign dsh = 65'(dd) << B;
		assign ge  = rem_s[s-1] >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[s]    <= q_s[s-1] | (QB'(ge) << B);
				neg_s[s]  <= neg_s[s-1];
				sat_s[s]  <= sat_s[s-1];
				zero_s[s] <= zero_s[s-1];
				pay_s[s]  <= pay_s[s-1];
			end
		end

		if (s < QB) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) rem_s[s] <= ge ? rem_s[s-1] - dsh : rem_s[s-1];
			end
		end
	end

	assign lim = (sat_s[QB] || q_s[QB] > WRAP_LIMIT) ? WRAP_LIMIT : q_s[QB];

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[QB]) quo <= '0;
			else if (neg_s[QB]) quo <= -$signed({1'b0, lim});
			else quo <= $signed({1'b0, lim});
			out_pay <= pay_s[QB];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/tmid_sqrt.sv
// Pipelined 64-bit square root, rounded to nearest and saturated to 31 bits,
// one result bit per stage. Uses tmid_pkg.
`default_nettype none

module tmid_sqrt
	import tmid_pkg::*;
#(
	parameter int PW = 96
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [63:0]   rad,
	input  logic [PW-1:0] in_pay,
	output logic          out_valid,
	output logic [30:0]   root,
	output logic [PW-1:0] out_pay
);

	localparam int NIT = 32;

	logic [NIT-1:0] v_s;
	logic [63:0]    op_s  [0:NIT-1];
	logic [63:0]    res_s [0:NIT-1];
	logic [PW-1:0]  pay_s [0:NIT-1];
	logic [63:0]    rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s       <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s       <= {v_s[NIT-2:0], in_valid};
			out_valid <= v_s[NIT-1];
		end
	end

	for (genvar t = 0; t < NIT; t++) begin : g_it
		logic [63:0] one;
		logic [63:0] op_in;
		logic [63:0] res_in;
		logic [PW-1:0] pay_in;

		assign one = 64'(1) << (62 - 2 * t);
		if (t == 0) begin : g_first
			assign op_in  = rad;
			assign res_in = '0;
			assign pay_in = in_pay;
		end else begin : g_next
			assign op_in  = op_s[t-1];
			assign res_in = res_s[t-1];
			assign pay_in = pay_s[t-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (op_in >= res_in + one) begin
					op_s[t]  <= op_in - (res_in + one);
					res_s[t] <= (res_in >> 1) + one;
				end else begin
					op_s[t]  <= op_in;
					res_s[t] <= res_in >> 1;
				end
				pay_s[t] <= pay_in;
			end
		end
	end

	assign rnd = (op_s[NIT-1] > res_s[NIT-1]) ? res_s[NIT-1] + 64'd1 : res_s[NIT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			root    <= (rnd > 64'h7fff_ffff) ? 31'h7fff_ffff : rnd[30:0];
			out_pay <= pay_s[NIT-1];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/triclinic_minimum_image_distance.sv
// Top level of the triclinic minimum-image distance block.
// Uses tmid_pkg, tmid_rdiv, tmid_sqrt and the assertion macro header.
//
// Each item on the pair channel holds two positions; each item on the result
// channel holds the minimum-image displacement (second minus first) and its
// length, all Q15.16 nm. Both channels move an item at a clock edge with valid
// high and stall low. One pair is accepted per cycle while pair_stall is low; a
// result passes through the three pipelined wrap dividers (33 stages each),
// the 27-way shift search and the 33-stage square root.
// An output register with one skid entry lets one more item arrive after the
// receiver stalls; the whole pipeline then holds until the skid drains.
// The cfg channel writes the box registers by index while the block is idle.
// Each accepted write to a box register starts a serial box reduction, during
// which cfg_ready is low and pair_stall is high. Reset loads the 10 nm cubic
// box, which is already reduced, so the block is ready right after reset.
`default_nettype none
`include "triclinic_minimum_image_distance_defines.svh"

module triclinic_minimum_image_distance
	import tmid_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pair_valid,
	output logic                 pair_stall,
	input  pair_t                pair,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	typedef enum logic [2:0] {
		RS_IDLE, RS_LOAD, RS_PREP, RS_DIV, RS_SIGN, RS_MUL, RS_APPLY, RS_FINISH
	} red_state_t;

	typedef enum logic [1:0] {STEP_CY, STEP_CX, STEP_BX} red_step_t;

	localparam int TREE_N [0:5] = '{27, 14, 7, 4, 2, 1};

	// Box registers, reduction engine.
	red_state_t  rstate_q;
	red_step_t   step_q;
	logic [6:0]  cnt_q;
	logic [30:0] box_ax_q, box_by_q, box_cz_q;
	logic signed [31:0] box_bx_q, box_cx_q, box_cy_q;
	logic signed [63:0] w_bx_q, w_cx_q, w_cy_q;
	logic [64:0] num_q;
	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic        dneg_q;
	logic [63:0] mpl_q, mca_q, mcb_q, acc_a_q, acc_b_q;
	logic [30:0] red_ax_q, red_by_q, red_cz_q;
	logic signed [31:0] red_bx_q, red_cx_q, red_cy_q;

	logic signed [63:0] dvn;
	logic [30:0] dvd;
	logic [63:0] dmag, mul_a, mul_b;
	logic [32:0] r2;
	logic        r_ge;
	logic        cfg_we;

	assign cfg_ready = (rstate_q == RS_IDLE);
	assign cfg_we    = cfg_valid && cfg_ready;

	always_comb begin
		case (step_q)
			STEP_CY: begin
				dvn   = w_cy_q;
				dvd   = box_by_q;
				mul_a = 64'(box_by_q);
				mul_b = w_bx_q;
			end
			STEP_CX: begin
				dvn   = w_cx_q;
				dvd   = box_ax_q;
				mul_a = 64'(box_ax_q);
				mul_b = '0;
			end
			default: begin
				dvn   = w_bx_q;
				dvd   = box_ax_q;
				mul_a = 64'(box_ax_q);
				mul_b = '0;
			end
		endcase
	end

	assign dmag = dvn[63] ? 64'(-dvn) : 64'(dvn);
	assign r2   = {rem_q, num_q[64]};
	assign r_ge = r2 >= 33'({dvd, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rstate_q <= RS_IDLE;
			step_q   <= STEP_CY;
			cnt_q    <= '0;
			box_ax_q <= BOX_DIAG_RESET;
			box_bx_q <= '0;
			box_by_q <= BOX_DIAG_RESET;
			box_cx_q <= '0;
			box_cy_q <= '0;
			box_cz_q <= BOX_DIAG_RESET;
			red_ax_q <= BOX_DIAG_RESET;
			red_bx_q <= '0;
			red_by_q <= BOX_DIAG_RESET;
			red_cx_q <= '0;
			red_cy_q <= '0;
			red_cz_q <= BOX_DIAG_RESET;
		end else begin
			case (rstate_q)
				RS_IDLE: begin
					if (cfg_we) begin
						rstate_q <= RS_LOAD;
						case (cfg_index)
							REG_BOX_A_X: box_ax_q <= cfg_data[30:0];
							REG_BOX_B_X: box_bx_q <= cfg_data;
							REG_BOX_B_Y: box_by_q <= cfg_data[30:0];
							REG_BOX_C_X: box_cx_q <= cfg_data;
							REG_BOX_C_Y: box_cy_q <= cfg_data;
							REG_BOX_C_Z: box_cz_q <= cfg_data[30:0];
							default: rstate_q <= RS_IDLE;
						endcase
					end
				end
				RS_LOAD: begin
					w_bx_q   <= 64'(box_bx_q);
					w_cx_q   <= 64'(box_cx_q);
					w_cy_q   <= 64'(box_cy_q);
					step_q   <= STEP_CY;
					rstate_q <= RS_PREP;
				end
				RS_PREP: begin
					dneg_q   <= dvn[63];
					num_q    <= {dmag, 1'b0} + 65'(dvd);
					rem_q    <= '0;
					quo_q    <= '0;
					cnt_q    <= 7'd64;
					rstate_q <= RS_DIV;
				end
				RS_DIV: begin
					rem_q <= r_ge ? 32'(r2 - 33'({dvd, 1'b0})) : r2[31:0];
					quo_q <= {quo_q[62:0], r_ge};
					num_q <= {num_q[63:0], 1'b0};
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == '0) rstate_q <= RS_SIGN;
				end
				RS_SIGN: begin
					if (dvd == '0) mpl_q <= '0;
					else mpl_q <= dneg_q ? -quo_q : quo_q;
					mca_q    <= mul_a;
					mcb_q    <= mul_b;
					acc_a_q  <= '0;
					acc_b_q  <= '0;
					cnt_q    <= 7'd63;
					rstate_q <= RS_MUL;
				end
				RS_MUL: begin
					if (mpl_q[0]) begin
						acc_a_q <= acc_a_q + mca_q;
						acc_b_q <= acc_b_q + mcb_q;
					end
					mca_q <= {mca_q[62:0], 1'b0};
					mcb_q <= {mcb_q[62:0], 1'b0};
					mpl_q <= {1'b0, mpl_q[63:1]};
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == '0) rstate_q <= RS_APPLY;
				end
				RS_APPLY: begin
					case (step_q)
						STEP_CY: begin
							w_cy_q   <= w_cy_q - $signed(acc_a_q);
							w_cx_q   <= w_cx_q - $signed(acc_b_q);
							step_q   <= STEP_CX;
							rstate_q <= RS_PREP;
						end
						STEP_CX: begin
							w_cx_q   <= w_cx_q - $signed(acc_a_q);
							step_q   <= STEP_BX;
							rstate_q <= RS_PREP;
						end
						default: begin
							w_bx_q   <= w_bx_q - $signed(acc_a_q);
							rstate_q <= RS_FINISH;
						end
					endcase
				end
				RS_FINISH: begin
					red_ax_q <= box_ax_q;
					red_bx_q <= sat32(w_bx_q);
					red_by_q <= box_by_q;
					red_cx_q <= sat32(w_cx_q);
					red_cy_q <= sat32(w_cy_q);
					red_cz_q <= box_cz_q;
					rstate_q <= RS_IDLE;
				end
				default: rstate_q <= RS_IDLE;
			endcase
		end
	end

	// Pair pipeline.
	logic en, busy, accept;
	logic skid_v_q, out_v_q;
	result_t out_q, skid_q;

	logic signed [63:0] va [0:2], vb [0:2], vc [0:2];
	logic signed [31:0] vc32 [0:2], vb32 [0:1];
	logic signed [31:0] ax32;

	assign busy       = (rstate_q != RS_IDLE);
	assign en         = !skid_v_q;
	assign pair_stall = skid_v_q || busy;
	assign accept     = pair_valid && !pair_stall;

	assign ax32    = $signed({1'b0, red_ax_q});
	assign vc32[0] = red_cx_q;
	assign vc32[1] = red_cy_q;
	assign vc32[2] = $signed({1'b0, red_cz_q});
	assign vb32[0] = red_bx_q;
	assign vb32[1] = $signed({1'b0, red_by_q});
	assign va[0]   = 64'(ax32);
	assign va[1]   = '0;
	assign va[2]   = '0;
	assign vb[0]   = 64'(vb32[0]);
	assign vb[1]   = 64'(vb32[1]);
	assign vb[2]   = '0;
	assign vc[0]   = 64'(vc32[0]);
	assign vc[1]   = 64'(vc32[1]);
	assign vc[2]   = 64'(vc32[2]);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14;
	logic signed [63:0] d_s1 [0:2], d_s2 [0:2], d_s3 [0:2], d_s4 [0:2], d_s5 [0:2];
	logic signed [63:0] d_s6 [0:2], d_s7 [0:2];
	logic signed [63:0] p_s2 [0:2], p_s4 [0:1], p_s6;
	logic signed [63:0] e_s8 [0:2][0:2];
	logic signed [63:0] f_s9 [0:8][0:2];
	logic signed [63:0] c_s10 [0:26][0:2];
	logic [31:0]        m_s11 [0:26][0:2];
	logic signed [31:0] x_s11 [0:26][0:2], x_s12 [0:26][0:2], x_s13 [0:26][0:2];
	logic [63:0]        q_s12 [0:26][0:2];
	logic [63:0]        h_s13 [0:26];
	logic [63:0]        l_s13 [0:26];

	logic [4:0]         lv_v;
	logic [63:0]        lv_d2 [0:5][0:26];
	logic [95:0]        lv_x  [0:5][0:26];

	logic               dc_v, db_v, da_v;
	logic signed [31:0] kc, kb, ka;
	logic [191:0]       dc_pay, db_pay, da_pay;

	logic               sq_v;
	logic [30:0]        sq_root;
	logic [95:0]        sq_pay;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			lv_v  <= '0;
		end else if (en) begin
			v_s1  <= accept;
			v_s2  <= dc_v;
			v_s3  <= v_s2;
			v_s4  <= db_v;
			v_s5  <= v_s4;
			v_s6  <= da_v;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			lv_v  <= {lv_v[3:0], v_s14};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= 64'(pair.second_x) - 64'(pair.first_x);
			d_s1[1] <= 64'(pair.second_y) - 64'(pair.first_y);
			d_s1[2] <= 64'(pair.second_z) - 64'(pair.first_z);
		end
	end

	tmid_rdiv #(.PW(192)) u_div_c (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.num(d_s1[2]), .den(red_cz_q), .in_pay({d_s1[0], d_s1[1], d_s1[2]}),
		.out_valid(dc_v), .quo(kc), .out_pay(dc_pay)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2[0] <= dc_pay[191:128];
			d_s2[1] <= dc_pay[127:64];
			d_s2[2] <= dc_pay[63:0];
			for (int n = 0; n < 3; n++) p_s2[n] <= vc32[n] * kc;
			for (int n = 0; n < 3; n++) d_s3[n] <= d_s2[n] - p_s2[n];
		end
	end

	tmid_rdiv #(.PW(192)) u_div_b (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s3),
		.num(d_s3[1]), .den(red_by_q), .in_pay({d_s3[0], d_s3[1], d_s3[2]}),
		.out_valid(db_v), .quo(kb), .out_pay(db_pay)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			d_s4[0] <= db_pay[191:128];
			d_s4[1] <= db_pay[127:64];
			d_s4[2] <= db_pay[63:0];
			for (int n = 0; n < 2; n++) p_s4[n] <= vb32[n] * kb;
			d_s5[0] <= d_s4[0] - p_s4[0];
			d_s5[1] <= d_s4[1] - p_s4[1];
			d_s5[2] <= d_s4[2];
		end
	end

	tmid_rdiv #(.PW(192)) u_div_a (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s5),
		.num(d_s5[0]), .den(red_ax_q), .in_pay({d_s5[0], d_s5[1], d_s5[2]}),
		.out_valid(da_v), .quo(ka), .out_pay(da_pay)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			d_s6[0] <= da_pay[191:128];
			d_s6[1] <= da_pay[127:64];
			d_s6[2] <= da_pay[63:0];
			p_s6    <= ax32 * ka;
			d_s7[0] <= d_s6[0] - p_s6;
			d_s7[1] <= d_s6[1];
			d_s7[2] <= d_s6[2];
			for (int i = 0; i < 3; i++) begin
				for (int n = 0; n < 3; n++) begin
					if (i == 0) e_s8[i][n] <= d_s7[n] - va[n];
					else if (i == 2) e_s8[i][n] <= d_s7[n] + va[n];
					else e_s8[i][n] <= d_s7[n];
				end
			end
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					for (int n = 0; n < 3; n++) begin
						if (j == 0) f_s9[i*3+j][n] <= e_s8[i][n] - vb[n];
						else if (j == 2) f_s9[i*3+j][n] <= e_s8[i][n] + vb[n];
						else f_s9[i*3+j][n] <= e_s8[i][n];
					end
				end
			end
			for (int f = 0; f < 9; f++) begin
				for (int l = 0; l < 3; l++) begin
					for (int n = 0; n < 3; n++) begin
						if (l == 0) c_s10[f*3+l][n] <= f_s9[f][n] - vc[n];
						else if (l == 2) c_s10[f*3+l][n] <= f_s9[f][n] + vc[n];
						else c_s10[f*3+l][n] <= f_s9[f][n];
					end
				end
			end
			for (int c = 0; c < 27; c++) begin
				for (int n = 0; n < 3; n++) begin
					if (c_s10[c][n] > 64'sh8000_0000 || c_s10[c][n] < -64'sh8000_0000)
						m_s11[c][n] <= 32'h8000_0000;
					else if (c_s10[c][n][63])
						m_s11[c][n] <= 32'(-c_s10[c][n]);
					else
						m_s11[c][n] <= c_s10[c][n][31:0];
					x_s11[c][n] <= sat32(c_s10[c][n]);
					q_s12[c][n] <= 64'(m_s11[c][n]) * 64'(m_s11[c][n]);
					x_s12[c][n] <= x_s11[c][n];
					x_s13[c][n] <= x_s12[c][n];
				end
				h_s13[c]    <= q_s12[c][0] + q_s12[c][1];
				l_s13[c]    <= q_s12[c][2];
				lv_d2[0][c] <= h_s13[c] + l_s13[c];
				lv_x[0][c]  <= {x_s13[c][0], x_s13[c][1], x_s13[c][2]};
			end
		end
	end

	// Ties go to the later candidate, so the right side wins on equal length.
	for (genvar L = 1; L <= 5; L++) begin : g_lvl
		always_ff @(posedge clk) begin
			if (en) begin
				for (int q = 0; q < TREE_N[L]; q++) begin
					if (2 * q + 1 < TREE_N[L-1]) begin
						if (lv_d2[L-1][2*q+1] <= lv_d2[L-1][2*q]) begin
							lv_d2[L][q] <= lv_d2[L-1][2*q+1];
							lv_x[L][q]  <= lv_x[L-1][2*q+1];
						end else begin
							lv_d2[L][q] <= lv_d2[L-1][2*q];
							lv_x[L][q]  <= lv_x[L-1][2*q];
						end
					end else begin
						lv_d2[L][q] <= lv_d2[L-1][2*q];
						lv_x[L][q]  <= lv_x[L-1][2*q];
					end
				end
			end
		end
	end

	tmid_sqrt #(.PW(96)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(lv_v[4]),
		.rad(lv_d2[5][0]), .in_pay(lv_x[5][0]),
		.out_valid(sq_v), .root(sq_root), .out_pay(sq_pay)
	);

	// Output register with one skid entry.
	result_t fresh;
	logic    take;

	assign fresh = '{disp_x: sq_pay[95:64], disp_y: sq_pay[63:32], disp_z: sq_pay[31:0],
		distance: sq_root};
	assign take  = out_v_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) skid_v_q <= 1'b0;
		end else if (sq_v) begin
			if (out_v_q && !take) skid_v_q <= 1'b1;
			else out_v_q <= 1'b1;
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) out_q <= skid_q;
		end else if (sq_v) begin
			if (out_v_q && !take) skid_q <= fresh;
			else out_q <= fresh;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

	`TMID_ASSERT_NOW(a_skid_has_out, clk, arst_n, skid_v_q, out_v_q)
	`TMID_ASSERT_NEXT(a_skid_drains, clk, arst_n, skid_v_q && !result_stall, out_v_q && !skid_v_q)
	`TMID_ASSERT_NEXT(a_write_reduces, clk, arst_n, cfg_valid && cfg_ready && cfg_index <= REG_BOX_C_Z, rstate_q == RS_LOAD)
	`TMID_ASSERT_NOW(a_no_accept_busy, clk, arst_n, rstate_q != RS_IDLE, !accept && !cfg_we)

endmodule

`default_nettype wire
